// File: src/assert_macros.svh
// Assertion macros used by the top RTL file of the rectangle merger.
// Depends on nothing; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/frdm_pkg.sv
// Types, codes and helpers of the frame-difference rectangle merger.
// Used by every module of the block; depends on nothing.
package frdm_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_LINE_WIDTH   = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_REDRAW_ALL   = 2'd2;

	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_DRAIN = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		PH_ACCEPT = 3'b001,
		PH_MERGE  = 3'b010,
		PH_FLUSH  = 3'b100
	} phase_t;

	typedef struct packed {
		logic        req_type;
		logic [31:0] cur_pixels;
		logic [31:0] prev_pixels;
	} req_t;

	typedef struct packed {
		logic       rect_valid;
		logic [8:0] rect_left;
		logic [7:0] rect_top;
		logic [8:0] rect_right;
		logic [8:0] rect_bottom;
		logic [7:0] color_index;
		logic       merge_pending;
		logic       frame_done;
		logic       rejected;
	} rsp_t;

	typedef struct packed {
		logic [7:0] line_width;
		logic [8:0] frame_height;
		logic       redraw_all;
	} cfg_t;

	// classified transaction held in the queue
	typedef struct packed {
		kind_t       kind;
		logic [31:0] cur;
		logic [3:0]  chg;
	} item_t;

	// one run: start, width, first line, height, color
	typedef struct packed {
		logic [7:0] x;
		logic [8:0] w;
		logic [7:0] top;
		logic [8:0] h;
		logic [7:0] color;
	} run_t;

	// rectangle fields of a finished run
	function automatic rsp_t emit_run(input rsp_t r, input run_t e);
		rsp_t o;
		logic [8:0] xe;
		o = r;
		xe = {1'b0, e.x} + e.w;
		o.rect_valid  = 1'b1;
		o.rect_left   = {e.x, 1'b0};
		o.rect_top    = e.top;
		o.rect_right  = {xe[7:0], 1'b0};
		o.rect_bottom = {1'b0, e.top} + e.h;
		o.color_index = e.color;
		return o;
	endfunction

endpackage

// File: src/frame_diff_rectangle_merger.sv
// Frame-difference rectangle merger: one pixel group of four per clock is taken
// into same-color runs while a group is queued and the result register is free;
// rejected pixel groups are taken at that rate too. A drain transaction that
// follows any other transaction waits for a clock without a step, for the
// registered read of the run memory, so back-to-back drains are not taken at that rate.
// Results leave through an output register, requests enter through a two-entry
// queue, so either side may stall on its own.
// Depends on frdm_pkg, frdm_front, frdm_back and assert_macros.svh.
`include "assert_macros.svh"
module frame_diff_rectangle_merger #(
	parameter int MAX_WIDTH  = 160,
	parameter int MAX_HEIGHT = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  frdm_pkg::req_t req_item,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output frdm_pkg::rsp_t rsp_item,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [8:0]     cfg_data
);
	import frdm_pkg::*;

	cfg_t  cfg_q;
	logic  head_valid, pop;
	item_t head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_width   <= 8'd160;
			cfg_q.frame_height <= 9'd210;
			cfg_q.redraw_all   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINE_WIDTH:   cfg_q.line_width   <= cfg_data[7:0];
				CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				CFG_REDRAW_ALL:   cfg_q.redraw_all   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	frdm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_item   (req_item),
		.redraw_all (cfg_q.redraw_all),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	frdm_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_item   (rsp_item)
	);

	// checks
	`ASSERT_IMPLY(a_rej_pending, clk, arst_n, rsp_valid && rsp_item.rejected, rsp_item.merge_pending)
	`ASSERT_IMPLY(a_done_idle, clk, arst_n, rsp_valid && rsp_item.frame_done, !rsp_item.merge_pending)
	`ASSERT_IMPLY(a_no_rect_zero, clk, arst_n, rsp_valid && !rsp_item.rect_valid, rsp_item.rect_left == 9'd0 && rsp_item.rect_right == 9'd0)
	`ASSERT_IMPLY(a_pop_queue, clk, arst_n, !head_valid, !pop)
endmodule

// File: src/frdm_front.sv
// Front part: accepts request transactions, classifies them and queues them.
// Depends on frdm_pkg.
module frdm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  frdm_pkg::req_t  req_item,
	input  logic            redraw_all,
	output logic            head_valid,
	output frdm_pkg::item_t head,
	input  logic            pop
);
	import frdm_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	item_t      cls;
	logic       push;

	// classify: kind and per-pixel change mask
	always_comb begin
		cls.kind = req_item.req_type ? KIND_DRAIN : KIND_PIXEL;
		cls.cur  = req_item.cur_pixels;
		for (int i = 0; i < 4; i++) begin
			cls.chg[i] = redraw_all ||
				(req_item.cur_pixels[8*i +: 8] != req_item.prev_pixels[8*i +: 8]);
		end
	end

	assign req_stall  = (count_q == 2'd2);
	assign push       = req_valid && !req_stall;
	assign head_valid = (count_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// File: src/frdm_back.sv
// Back part: run building, line merge and flush, run memory, result register.
// Depends on frdm_pkg.
module frdm_back #(
	parameter int MAX_WIDTH  = 160,
	parameter int MAX_HEIGHT = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  frdm_pkg::cfg_t  cfg,
	input  logic            head_valid,
	input  frdm_pkg::item_t head,
	output logic            pop,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output frdm_pkg::rsp_t  rsp_item
);
	import frdm_pkg::*;

	localparam int DEPTH = (MAX_WIDTH + 3) / 4;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [8:0] MAXW = 9'(MAX_WIDTH);
	localparam logic [8:0] MAXH = 9'(MAX_HEIGHT);

	phase_t     phase_q, n_phase;
	logic       ls_q, n_ls;
	logic [8:0] cur_cnt_q, n_cur_cnt, open_cnt_q, n_open_cnt;
	logic [8:0] cc_q, n_cc, oc_q, n_oc;
	logic [7:0] col_q, n_col, line_q, n_line;
	logic [7:0] tail_x_q, n_tail_x, tail_c_q, n_tail_c;
	logic [8:0] tail_w_q, n_tail_w;
	logic       fresh_q;
	logic       out_valid_q;
	rsp_t       out_q;

	logic          step, out_free, res_make, do_fin;
	rsp_t          res;
	logic [8:0]    fin_cnt;
	logic [3:0]    bank_we;
	logic [AW-1:0] bank_wa [4];
	run_t          bank_wd [4];
	run_t          rd_q [2][4];
	run_t          c_run, a_run;

	// chain variables
	logic [8:0] cnt, tw, px, cend, aend, eff_h, idx;
	logic [7:0] tx, tc, pc;
	logic       ext;
	run_t       upd;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign step      = head_valid && out_free && (head.kind == KIND_PIXEL || fresh_q);
	assign pop       = step;
	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_q;
	assign c_run     = rd_q[ls_q][cc_q[1:0]];
	assign a_run     = rd_q[!ls_q][oc_q[1:0]];

	always_comb begin
		if (cfg.frame_height == 9'd0)   eff_h = 9'd1;
		else if (cfg.frame_height > MAXH) eff_h = MAXH;
		else                              eff_h = cfg.frame_height;
	end

	// next state of one transaction
	always_comb begin
		n_phase = phase_q; n_ls = ls_q; n_cur_cnt = cur_cnt_q; n_open_cnt = open_cnt_q;
		n_cc = cc_q; n_oc = oc_q; n_col = col_q; n_line = line_q;
		n_tail_x = tail_x_q; n_tail_w = tail_w_q; n_tail_c = tail_c_q;
		res_make = 1'b0; res = '0; do_fin = 1'b0; fin_cnt = cur_cnt_q;
		bank_we = '0;
		for (int b = 0; b < 4; b++) begin
			bank_wa[b] = '0;
			bank_wd[b] = '0;
		end
		cnt = cur_cnt_q; tx = tail_x_q; tw = tail_w_q; tc = tail_c_q;
		px = '0; pc = '0; ext = 1'b0; idx = '0; cend = '0; aend = '0; upd = '0;
		if (step) begin
			if (head.kind == KIND_PIXEL) begin
				if (phase_q != PH_ACCEPT) begin
					res_make = 1'b1;
					res.rejected = 1'b1;
				end else begin
					// extend the tail run or open new runs, four pixels
					for (int i = 0; i < 4; i++) begin
						px = {1'b0, col_q} + 9'(i);
						pc = head.cur[8*i +: 8];
						ext = (cnt != 9'd0) && (tc == pc) && (({1'b0, tx} + tw) == px);
						if (px < {1'b0, cfg.line_width} && px < MAXW && head.chg[i]) begin
							if (ext) begin
								tw = tw + 9'd1;
								idx = cnt - 9'd1;
								bank_we[idx[1:0]] = 1'b1;
								bank_wa[idx[1:0]] = AW'(idx[8:2]);
								bank_wd[idx[1:0]] = {tx, tw, line_q, 9'd1, tc};
							end else if (cnt < MAXW) begin
								tx = px[7:0];
								tw = 9'd1;
								tc = pc;
								idx = cnt;
								bank_we[idx[1:0]] = 1'b1;
								bank_wa[idx[1:0]] = AW'(idx[8:2]);
								bank_wd[idx[1:0]] = {tx, tw, line_q, 9'd1, tc};
								cnt = cnt + 9'd1;
							end
						end
					end
					n_cur_cnt = cnt; n_tail_x = tx; n_tail_w = tw; n_tail_c = tc;
					if (({1'b0, col_q} + 9'd4) >= {1'b0, cfg.line_width}) begin
						res_make = 1'b1;
						n_col = '0; n_cc = '0; n_oc = '0;
						if (open_cnt_q == 9'd0) begin
							do_fin = 1'b1;
							fin_cnt = cnt;
						end else begin
							n_phase = PH_MERGE;
						end
					end else begin
						n_col = col_q + 8'd4;
					end
				end
			end else begin
				res_make = 1'b1;
				case (phase_q)
					PH_MERGE: begin
						if (cc_q < cur_cnt_q && cc_q < MAXW) begin
							if (c_run.x == a_run.x && c_run.w == a_run.w &&
									c_run.color == a_run.color) begin
								// same run one line further down
								upd = c_run;
								upd.top = a_run.top;
								upd.h = a_run.h + 9'd1;
								bank_we[cc_q[1:0]] = 1'b1;
								bank_wa[cc_q[1:0]] = AW'(cc_q[8:2]);
								bank_wd[cc_q[1:0]] = upd;
								n_oc = oc_q + 9'd1;
								n_cc = cc_q + 9'd1;
							end else begin
								cend = {1'b0, c_run.x} + c_run.w;
								aend = {1'b0, a_run.x} + a_run.w;
								if (cend > {1'b0, a_run.x}) begin
									res = emit_run(res, a_run);
									n_oc = oc_q + 9'd1;
								end
								if (cend <= aend) n_cc = cc_q + 9'd1;
							end
						end else begin
							res = emit_run(res, a_run);
							n_oc = oc_q + 9'd1;
						end
						if (n_oc >= open_cnt_q) begin
							do_fin = 1'b1;
							fin_cnt = cur_cnt_q;
						end
					end
					PH_FLUSH: begin
						res = emit_run(res, a_run);
						n_oc = oc_q + 9'd1;
						if (n_oc >= open_cnt_q) begin
							res.frame_done = 1'b1;
							n_open_cnt = '0; n_cur_cnt = '0; n_oc = '0; n_cc = '0;
							n_line = '0; n_col = '0; n_phase = PH_ACCEPT;
						end
					end
					default: ;
				endcase
			end
			// line finished: swap lists
			if (do_fin) begin
				n_ls = !ls_q;
				n_open_cnt = fin_cnt;
				n_cur_cnt = '0; n_cc = '0; n_oc = '0; n_col = '0;
				if (({1'b0, line_q} + 9'd1) >= eff_h) begin
					n_line = '0;
					if (fin_cnt == 9'd0) begin
						res.frame_done = 1'b1;
						n_open_cnt = '0;
						n_phase = PH_ACCEPT;
					end else begin
						n_phase = PH_FLUSH;
					end
				end else begin
					n_line = line_q + 8'd1;
					n_phase = PH_ACCEPT;
				end
			end
			res.merge_pending = (n_phase != PH_ACCEPT);
		end
	end

	// run memory: two lists by four banks, one write and one read each
	for (genvar l = 0; l < 2; l++) begin : g_list
		for (genvar b = 0; b < 4; b++) begin : g_bank
			run_t          mem [DEPTH];
			logic [AW-1:0] ra;
			assign ra = (ls_q == 1'(l)) ? AW'(cc_q[8:2]) : AW'(oc_q[8:2]);
			always_ff @(posedge clk) begin
				if (bank_we[b] && ls_q == 1'(l)) mem[bank_wa[b]] <= bank_wd[b];
				rd_q[l][b] <= mem[ra];
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step && res_make) out_q <= res;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ACCEPT; ls_q <= 1'b0;
			cur_cnt_q <= '0; open_cnt_q <= '0; cc_q <= '0; oc_q <= '0;
			col_q <= '0; line_q <= '0;
			tail_x_q <= '0; tail_w_q <= '0; tail_c_q <= '0;
			fresh_q <= 1'b0; out_valid_q <= 1'b0;
		end else begin
			phase_q <= n_phase; ls_q <= n_ls;
			cur_cnt_q <= n_cur_cnt; open_cnt_q <= n_open_cnt;
			cc_q <= n_cc; oc_q <= n_oc; col_q <= n_col; line_q <= n_line;
			tail_x_q <= n_tail_x; tail_w_q <= n_tail_w; tail_c_q <= n_tail_c;
			// read data matches the cursors only when the last clock had no step
			fresh_q <= !step;
			if (step && res_make) out_valid_q <= 1'b1;
			else if (!rsp_stall)  out_valid_q <= 1'b0;
		end
	end
endmodule

// File: tb/tb.sv
// Self-checking testbench for frame_diff_rectangle_merger: random frames of colour
// groups with drain ticks are predicted in step with the stimulus and checked.
// Depends on frdm_pkg and the RTL of the merger.
`timescale 1ns / 1ps
module tb;
	import frdm_pkg::*;

	localparam int WMAX = 160;
	localparam int HMAX = 256;
	localparam int TARGET = 1450;
	localparam int CYCLE_LIMIT = 800000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_item = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_item;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_LINE_WIDTH;
	logic [8:0] cfg_data = '0;

	frame_diff_rectangle_merger u_dut (.*);

	always #4 clk = ~clk;

	// queues between the stimulus, the driver and the checker
	req_t pending_reqs[$];
	rsp_t expected_rects[$];
	int errors = 0;
	int n_pushed = 0;
	int n_accepted = 0;
	int send_idle = 38, recv_idle = 69;
	int recv_hold = 0;
	bit hold_done = 0;

	// mirror of the block state
	int unsigned m_width, m_height, m_redraw;
	int unsigned rx[2][WMAX], rw[2][WMAX], rtop[2][WMAX], rh[2][WMAX], rcol[2][WMAX];
	int unsigned sel, cur_cnt, open_cnt, cur_cur, open_cur, col, line;
	phase_t ph;

	function automatic void rect_of(int unsigned s, int unsigned i, ref rsp_t o);
		o.rect_valid  = 1'b1;
		o.rect_left   = 9'((rx[s][i] * 2) & 'h1FF);
		o.rect_top    = 8'(rtop[s][i] & 'hFF);
		o.rect_right  = 9'(((rx[s][i] + rw[s][i]) * 2) & 'h1FF);
		o.rect_bottom = 9'((rtop[s][i] + rh[s][i]) & 'h1FF);
		o.color_index = 8'(rcol[s][i] & 'hFF);
	endfunction

	function automatic void close_frame(ref rsp_t o);
		o.frame_done = 1'b1;
		open_cnt = 0; cur_cnt = 0; open_cur = 0; cur_cur = 0;
		line = 0; col = 0; ph = PH_ACCEPT;
	endfunction

	function automatic void close_line(ref rsp_t o);
		int unsigned h;
		h = (m_height == 0) ? 1 : (m_height > HMAX) ? HMAX : m_height;
		sel ^= 1;
		open_cnt = cur_cnt; cur_cnt = 0; open_cur = 0; cur_cur = 0; col = 0;
		if (line + 1 >= h) begin
			line = 0;
			if (open_cnt == 0) close_frame(o);
			else ph = PH_FLUSH;
		end else begin
			line++;
			ph = PH_ACCEPT;
		end
	endfunction

	// one merge step between current runs and open runs of the line above
	function automatic void merge_one(ref rsp_t o);
		int unsigned c, a, cend, aend;
		c = sel; a = sel ^ 1;
		if (open_cur >= open_cnt || open_cur >= WMAX) return;
		if (cur_cur < cur_cnt && cur_cur < WMAX) begin
			if (rx[c][cur_cur] == rx[a][open_cur] && rw[c][cur_cur] == rw[a][open_cur] &&
			    rcol[c][cur_cur] == rcol[a][open_cur]) begin
				rtop[c][cur_cur] = rtop[a][open_cur];
				rh[c][cur_cur] = rh[a][open_cur] + 1;
				open_cur++; cur_cur++;
			end else begin
				cend = rx[c][cur_cur] + rw[c][cur_cur];
				aend = rx[a][open_cur] + rw[a][open_cur];
				if (cend > rx[a][open_cur]) begin
					rect_of(a, open_cur, o);
					open_cur++;
				end
				if (cend <= aend) cur_cur++;
			end
		end else begin
			rect_of(a, open_cur, o);
			open_cur++;
		end
	endfunction

	// pixel group into runs of the current line
	function automatic void add_group(logic [31:0] cp, logic [31:0] pp);
		int unsigned px, c, p, n;
		for (int i = 0; i < 4; i++) begin
			px = col + i;
			c = cp[8*i +: 8];
			p = pp[8*i +: 8];
			if (px >= m_width || px >= WMAX) continue;
			if (m_redraw == 0 && c == p) continue;
			n = cur_cnt;
			if (n != 0 && n <= WMAX && rcol[sel][n-1] == c && rx[sel][n-1] + rw[sel][n-1] == px)
				rw[sel][n-1]++;
			else if (n < WMAX) begin
				rx[sel][n] = px; rw[sel][n] = 1; rtop[sel][n] = line;
				rh[sel][n] = 1; rcol[sel][n] = c;
				cur_cnt++;
			end
		end
	endfunction

	// expected result of one transaction; returns 1 when the block answers
	function automatic bit predict_rect(req_t r, ref rsp_t o);
		int unsigned a;
		o = '0;
		if (r.req_type == KIND_PIXEL) begin
			if (ph != PH_ACCEPT) begin
				o.merge_pending = 1'b1;
				o.rejected = 1'b1;
				return 1;
			end
			add_group(r.cur_pixels, r.prev_pixels);
			if (col + 4 >= m_width) begin
				col = 0; cur_cur = 0; open_cur = 0;
				if (open_cnt == 0) close_line(o);
				else ph = PH_MERGE;
				o.merge_pending = (ph != PH_ACCEPT);
				return 1;
			end
			col += 4;
			return 0;
		end
		if (ph == PH_MERGE) begin
			merge_one(o);
			if (open_cur >= open_cnt) close_line(o);
		end else if (ph == PH_FLUSH) begin
			a = sel ^ 1;
			if (open_cur < open_cnt && open_cur < WMAX) begin
				rect_of(a, open_cur, o);
				open_cur++;
			end
			if (open_cur >= open_cnt || open_cur >= WMAX) close_frame(o);
		end
		o.merge_pending = (ph != PH_ACCEPT);
		return 1;
	endfunction

	// clock-cycle limit
	int cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) n_accepted <= n_accepted + 1;
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
					req_item <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// idling schedule by transaction count
	always @(posedge clk) begin
		if (n_accepted >= 2 * TARGET / 3) begin
			send_idle <= 0; recv_idle <= 0;
		end else if (n_accepted >= TARGET / 3) begin
			send_idle <= 69; recv_idle <= 38;
		end
	end

	task automatic check_field(string name, int unsigned e, int unsigned a);
		if (e != a) begin
			errors++;
			$display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, e, a);
		end
	endtask

	// result monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rects.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none actual %p", $realtime, rsp_item);
				end else begin
					e = expected_rects.pop_front();
					check_field("rect_valid", e.rect_valid, rsp_item.rect_valid);
					check_field("rect_left", e.rect_left, rsp_item.rect_left);
					check_field("rect_top", e.rect_top, rsp_item.rect_top);
					check_field("rect_right", e.rect_right, rsp_item.rect_right);
					check_field("rect_bottom", e.rect_bottom, rsp_item.rect_bottom);
					check_field("color_index", e.color_index, rsp_item.color_index);
					check_field("merge_pending", e.merge_pending, rsp_item.merge_pending);
					check_field("frame_done", e.frame_done, rsp_item.frame_done);
					check_field("rejected", e.rejected, rsp_item.rejected);
				end
			end
			// long hold-off once, so the input queue backs up
			if (!hold_done && n_accepted >= 300) begin
				hold_done <= 1'b1;
				recv_hold <= 200;
				rsp_stall <= 1'b1;
			end else if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	// stimulus
	logic [31:0] last_line[64];

	task automatic push_req(logic kind, logic [31:0] cp, logic [31:0] pp, output rsp_t o,
	                        output bit got);
		req_t r;
		r.req_type = kind;
		r.cur_pixels = cp;
		r.prev_pixels = pp;
		got = predict_rect(r, o);
		if (got) expected_rects.push_back(o);
		pending_reqs.push_back(r);
		n_pushed++;
	endtask

	task automatic wait_quiet();
		while (pending_reqs.size() > 0 || req_valid || expected_rects.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [8:0] val);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_LINE_WIDTH:   m_width = val[7:0];
			CFG_FRAME_HEIGHT: m_height = val;
			default:          m_redraw = val[0];
		endcase
	endtask

	task automatic set_frame(int unsigned w, int unsigned h, int unsigned rd);
		wait_quiet();
		write_reg(CFG_LINE_WIDTH, 9'(w));
		write_reg(CFG_FRAME_HEIGHT, 9'(h));
		write_reg(CFG_REDRAW_ALL, 9'(rd));
	endtask

	function automatic logic [7:0] pick_color(int mode);
		if (mode == 1) return 8'h00;
		if (mode == 2) return 8'hFF;
		if ($urandom_range(9) == 0) return 8'($urandom);
		return 8'($urandom_range(3));
	endfunction

	// a full frame; mode 1 all zero, 2 all ones, 0 random. noise adds stray requests
	task automatic run_frame(int mode, int noise);
		rsp_t o;
		bit got;
		int g;
		logic [31:0] cp, pp;
		forever begin
			g = 0;
			// pixel groups until the line ends
			do begin
				if (mode == 0 && $urandom_range(99) < 60 && g < 64) cp = last_line[g];
				else for (int i = 0; i < 4; i++) cp[8*i +: 8] = pick_color(mode);
				for (int i = 0; i < 4; i++)
					pp[8*i +: 8] = ($urandom_range(1) || mode != 0) ? cp[8*i +: 8] : 8'($urandom);
				if (mode == 2) pp = ~cp;
				if (g < 64) last_line[g] = cp;
				if (noise > 0 && $urandom_range(99) < noise) begin
					push_req(KIND_DRAIN, $urandom, $urandom, o, got);
				end
				push_req(KIND_PIXEL, cp, pp, o, got);
				g++;
			end while (!got);
			// drain the merge, sometimes with stray pixel groups
			while (o.merge_pending) begin
				if (noise > 0 && $urandom_range(99) < noise)
					push_req(KIND_PIXEL, $urandom, $urandom, o, got);
				else
					push_req(KIND_DRAIN, $urandom, $urandom, o, got);
				if (o.frame_done) return;
			end
			if (o.frame_done) return;
		end
	endtask

	initial begin
		rsp_t o;
		bit got;
		int unsigned w, h;
		m_width = 160; m_height = 210; m_redraw = 1;
		sel = 0; cur_cnt = 0; open_cnt = 0; cur_cur = 0; open_cur = 0; col = 0; line = 0;
		ph = PH_ACCEPT;
		foreach (last_line[i]) last_line[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: drain while idle, extreme colours, no change, stray requests
		push_req(KIND_DRAIN, '1, '1, o, got);
		set_frame(8, 3, 1);
		run_frame(1, 0);
		set_frame(8, 2, 0);
		run_frame(2, 0);
		set_frame(4, 2, 0);
		run_frame(1, 0);
		set_frame(5, 0, 1);
		run_frame(0, 30);
		set_frame(0, 2, 1);
		run_frame(0, 0);
		// tallest frame, height clipped to the maximum, one run growing all the way down
		set_frame(4, 300, 1);
		run_frame(1, 0);

		// random frames, mostly small
		while (n_pushed < TARGET) begin
			case ($urandom_range(19))
				0:       begin w = 160; h = $urandom_range(1, 2); end
				1:       begin w = 255; h = 1; end
				2:       begin w = 4; h = $urandom_range(6, 40); end
				3:       begin w = $urandom_range(255); h = $urandom_range(0, 2); end
				default: begin w = 4 * $urandom_range(1, 6); h = $urandom_range(1, 5); end
			endcase
			set_frame(w, h, $urandom_range(1));
			run_frame(0, ($urandom_range(3) == 0) ? 10 : 0);
		end

		wait_quiet();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
